### src/iirdf1_pkg.sv
// Shared types and constants for the direct-form-I recursive filter.
package iirdf1_pkg;

   // Sample and coefficient formats
   localparam int SampleWidth = 16;
   localparam int CoefWidth   = 16;
   localparam int FracBits    = 14;

   // Filter tap count and delay line depth
   localparam int FilterTaps = 4;
   localparam int HistDepth  = 3;

   // Accumulator: one product, plus three guard bits for seven terms
   localparam int ProdWidth = SampleWidth + CoefWidth;
   localparam int AccWidth  = ProdWidth + 3;

   // Register file
   localparam int NumRegs       = 7;
   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] RegFeed0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegFeed1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegFeed2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegFeed3 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegBack1 = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegBack2 = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegBack3 = 3'd6;

   // Reset of feed_coef_0 is 1.0 in Q2.14
   localparam logic [CoefWidth-1:0] Feed0Reset = CoefWidth'(1 << FracBits);

   // Coefficient set: feed[0..3] is b0..b3, back[0..2] is a1..a3
   typedef struct packed {
      logic [HistDepth:0][CoefWidth-1:0]   feed;
      logic [HistDepth-1:0][CoefWidth-1:0] back;
   } coef_set_type;

endpackage

### src/iir_direct_form_one_filter_top.sv
// Top level of the order-three direct-form-I recursive filter.
// Input channel req_*: one signed 16-bit sample per transaction, plus
// req_block_start, which clears both delay lines before that sample is used.
// Result channel rsp_*: one filtered sample per input, rounded half up,
// shifted right by 14 and saturated to 16 bits; rsp_saturated marks clipping.
// Configuration channel csr_*: seven Q2.14 coefficients, b0..b3 at index
// 0..3 and a1..a3 at index 4..6; csr_ready is always high, other indexes
// are ignored. Write only while no transaction is in flight.
// A sample passes stage 1 and stage 2 and is then registered as the result.
// Throughput: one sample per cycle while rsp_stall is low. The bound is the
// output feedback loop: three multipliers on the past outputs, the final
// sum, rounding and saturation all sit in the last stage, so each result is
// ready in time for the next sample.
// A stalled result holds in the output register; earlier stages keep
// filling until every stage is full, only then is req_stall raised.
// Reset (synchronous) empties the pipeline, zeroes both delay lines and
// loads b0 = 1.0 with all other coefficients zero.
module iir_direct_form_one_filter_top (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [iirdf1_pkg::SampleWidth-1:0]   req_sample_in,
   input  logic                                        req_block_start,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [iirdf1_pkg::SampleWidth-1:0]   rsp_sample_out,
   output logic                                        rsp_saturated,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [iirdf1_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [iirdf1_pkg::CoefWidth-1:0]            csr_wdata
);
   import iirdf1_pkg::*;

   localparam int YWidth = AccWidth - FracBits;

   coef_set_type coef;

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load3, load2, load1, move1, move2, accept;

   // Stage 1: sample and a snapshot of the input delay line
   logic signed [SampleWidth-1:0]   s1_x_ff, s1_x_in;
   logic [HistDepth-1:0][SampleWidth-1:0] s1_xh_ff, s1_xh_in;
   logic                            s1_bs_ff, s1_bs_in;
   logic [HistDepth-1:0][SampleWidth-1:0] x_hist_ff, x_hist_in;
   logic [HistDepth-1:0][SampleWidth-1:0] x_base;

   // Stage 2: forward sum
   logic signed [AccWidth-1:0]      s2_fwd_ff, s2_fwd_in;
   logic                            s2_bs_ff, s2_bs_in;

   // Stage 3: feedback, rounding, saturation
   logic [HistDepth-1:0][SampleWidth-1:0] y_hist_ff, y_hist_in;
   logic [HistDepth-1:0][SampleWidth-1:0] y_base;
   logic signed [AccWidth-1:0]      acc_full;
   logic signed [YWidth-1:0]        y_wide;
   logic signed [SampleWidth-1:0]   y_sat;
   logic                            y_clip;
   logic signed [SampleWidth-1:0]   rsp_sample_out_ff, rsp_sample_out_in;
   logic                            rsp_saturated_ff, rsp_saturated_in;

   iirdf1_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // Each stage loads when it is empty or its content moves on
   always_comb begin
      load3  = !rsp_valid_ff || !rsp_stall;
      load2  = !s2_valid_ff || load3;
      load1  = !s1_valid_ff || load2;
      move2  = s2_valid_ff && load3;
      move1  = s1_valid_ff && load2;
      accept = req_valid && load1;
   end

   assign req_stall = !load1;

   always_comb begin
      s1_valid_in  = load1 ? req_valid : s1_valid_ff;
      s2_valid_in  = load2 ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = load3 ? s2_valid_ff : rsp_valid_ff;
   end

   // Input delay line, cleared by block start before use
   always_comb begin
      x_base    = req_block_start ? '0 : x_hist_ff;
      x_hist_in = x_hist_ff;
      s1_x_in   = s1_x_ff;
      s1_xh_in  = s1_xh_ff;
      s1_bs_in  = s1_bs_ff;
      if (accept) begin
         x_hist_in[0] = req_sample_in;
         for (int k = 1; k < HistDepth; k++) begin
            x_hist_in[k] = x_base[k-1];
         end
         s1_x_in  = req_sample_in;
         s1_xh_in = x_base;
         s1_bs_in = req_block_start;
      end
   end

   // Forward products b0*x[n] .. b3*x[n-3]
   always_comb begin
      logic signed [ProdWidth-1:0] prod;
      logic signed [AccWidth-1:0]  sum;
      prod = $signed(coef.feed[0]) * s1_x_ff;
      sum  = AccWidth'(prod);
      for (int j = 1; j <= HistDepth; j++) begin
         prod = $signed(coef.feed[j]) * $signed(s1_xh_ff[j-1]);
         if (j < FilterTaps) begin
            sum = sum + AccWidth'(prod);
         end
      end
      s2_fwd_in = move1 ? sum : s2_fwd_ff;
      s2_bs_in  = move1 ? s1_bs_ff : s2_bs_ff;
   end

   // Feedback products a1*y[n-1] .. a3*y[n-3], then round half up
   always_comb begin
      logic signed [ProdWidth-1:0] prod;
      y_base   = s2_bs_ff ? '0 : y_hist_ff;
      acc_full = s2_fwd_ff;
      for (int j = 1; j <= HistDepth; j++) begin
         prod = $signed(coef.back[j-1]) * $signed(y_base[j-1]);
         if (j < FilterTaps) begin
            acc_full = acc_full - AccWidth'(prod);
         end
      end
      acc_full = acc_full + AccWidth'(1 << (FracBits - 1));
      y_wide   = acc_full[AccWidth-1:FracBits];
   end

   // Saturate: out of range when the bits above the sample's sign differ
   always_comb begin
      y_clip = (y_wide[YWidth-1:SampleWidth-1] != '0) &&
               (y_wide[YWidth-1:SampleWidth-1] != '1);
      if (!y_clip) begin
         y_sat = y_wide[SampleWidth-1:0];
      end else if (y_wide[YWidth-1]) begin
         y_sat = {1'b1, {(SampleWidth-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SampleWidth-1){1'b1}}};
      end
   end

   // Output delay line and result register
   always_comb begin
      y_hist_in         = y_hist_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_saturated_in  = rsp_saturated_ff;
      if (move2) begin
         y_hist_in[0] = y_sat;
         for (int k = 1; k < HistDepth; k++) begin
            y_hist_in[k] = y_base[k-1];
         end
         rsp_sample_out_in = y_sat;
         rsp_saturated_in  = y_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_hist_ff    <= '0;
         y_hist_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         x_hist_ff    <= x_hist_in;
         y_hist_ff    <= y_hist_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_x_ff           <= s1_x_in;
      s1_xh_ff          <= s1_xh_in;
      s1_bs_ff          <= s1_bs_in;
      s2_fwd_ff         <= s2_fwd_in;
      s2_bs_ff          <= s2_bs_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_saturated  = rsp_saturated_ff;

`ifndef ASSERT_OFF
   // Input is held back only while stage 1 holds a transaction
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall with empty first stage");

   // A forward sum that may advance shows up as a result next cycle
   a_stage2_drains: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && load3) |=> rsp_valid_ff)
      else $error("stage 2 transaction lost");

   // A clipped result sits at one of the two range limits
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |->
         (rsp_sample_out_ff == {1'b0, {(SampleWidth-1){1'b1}}} ||
          rsp_sample_out_ff == {1'b1, {(SampleWidth-1){1'b0}}}))
      else $error("saturated flag with in-range value");

   // Reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

### src/iirdf1_csr.sv
// Coefficient register file with its write port.
module iirdf1_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [iirdf1_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [iirdf1_pkg::CoefWidth-1:0]        csr_wdata,
   output iirdf1_pkg::coef_set_type                coef
);
   import iirdf1_pkg::*;

   coef_set_type coef_ff;
   coef_set_type coef_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   // Decode register index; indexes past the last register are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            RegFeed0: coef_in.feed[0] = csr_wdata;
            RegFeed1: coef_in.feed[1] = csr_wdata;
            RegFeed2: coef_in.feed[2] = csr_wdata;
            RegFeed3: coef_in.feed[3] = csr_wdata;
            RegBack1: coef_in.back[0] = csr_wdata;
            RegBack2: coef_in.back[1] = csr_wdata;
            RegBack3: coef_in.back[2] = csr_wdata;
            default:  coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff         <= '0;
         coef_ff.feed[0] <= Feed0Reset;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule
